// ===== hdl/icc_pkg.sv =====
`default_nettype none

package icc_pkg;

    localparam int START_W     = 26;
    localparam int INC_W       = 22;
    localparam int ELAPSED_W   = 10;
    localparam int PIPE_STAGES = 7;

    localparam int MS_PER_SEC      = 1000;
    localparam int SEC_PER_MIN     = 60;
    localparam int MIN_MODE_LIMIT  = 99;
    localparam int SEC_MODE_LIMIT  = 9;
    localparam int MS_PER_TENTH    = 100;
    localparam int MINUTES_MAX     = 2047;

    // rem / 100 for rem < 1000 as (rem * 41) >> 12
    localparam int TENTH_MUL   = 41;
    localparam int TENTH_SHIFT = 12;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_MOVE   = 3'd1,
        ACT_START  = 3'd2,
        ACT_STOP   = 3'd3,
        ACT_RESUME = 3'd4
    } action_t;

    typedef enum logic [0:0] {
        REG_START_TIME = 1'd0,
        REG_INCREMENT  = 1'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_MIN       = 2'd0,
        MODE_MIN_SEC   = 2'd1,
        MODE_SEC_TENTH = 2'd2
    } disp_mode_t;

    typedef struct packed {
        logic white_to_move;
        logic running;
        logic white_flag;
        logic black_flag;
    } flags_t;

    typedef struct packed {
        disp_mode_t  mode;
        logic [10:0] minutes;
        logic [5:0]  seconds;
        logic [3:0]  tenths;
    } disp_t;

    typedef logic [PIPE_STAGES:1] stage_en_t;

endpackage

`default_nettype wire

// ===== hdl/icc_state.sv =====
`default_nettype none

module icc_state
    import icc_pkg::*;
#(
    parameter int TIME_BITS = 26
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   accept,
    input  wire  [2:0]            action,
    input  wire  [ELAPSED_W-1:0]  elapsed,
    input  wire  [START_W-1:0]    start_time,
    input  wire  [INC_W-1:0]      increment,
    output logic [TIME_BITS-1:0]  white_next,
    output logic [TIME_BITS-1:0]  black_next,
    output flags_t                flags_next,
    output flags_t                flags_cur
);

    localparam int SUM_W  = ((TIME_BITS > INC_W) ? TIME_BITS : INC_W) + 1;
    localparam int LOAD_W = (TIME_BITS > START_W) ? TIME_BITS : START_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [TIME_BITS-1:0] white_reg;
    logic [TIME_BITS-1:0] black_reg;
    flags_t               flags_reg;

    logic [TIME_BITS-1:0] cur;
    logic [TIME_BITS-1:0] new_cur;
    logic [TIME_BITS-1:0] el_ext;
    logic [SUM_W-1:0]     sum;
    logic [TIME_BITS-1:0] inc_sat;
    logic [TIME_BITS-1:0] load_sat;
    logic                 expired;
    logic                 write_cur;

    always_comb
    begin
        cur      = flags_reg.white_to_move ? white_reg : black_reg;
        el_ext   = TIME_BITS'(elapsed);
        expired  = !(cur > el_ext);
        sum      = SUM_W'(cur) + SUM_W'(increment);
        inc_sat  = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
        load_sat = (LOAD_W'(start_time) > LOAD_W'(TIME_MAX)) ? TIME_MAX
                                                             : TIME_BITS'(start_time);

        new_cur    = cur;
        write_cur  = 1'b0;
        white_next = white_reg;
        black_next = black_reg;
        flags_next = flags_reg;

        case (action)
            ACT_TICK:
            begin
                if (flags_reg.running)
                begin
                    write_cur = 1'b1;
                    if (expired)
                    begin
                        new_cur            = '0;
                        flags_next.running = 1'b0;
                        if (flags_reg.white_to_move)
                            flags_next.white_flag = 1'b1;
                        else
                            flags_next.black_flag = 1'b1;
                    end
                    else
                    begin
                        new_cur = cur - el_ext;
                    end
                end
            end
            ACT_MOVE:
            begin
                write_cur                = 1'b1;
                new_cur                  = inc_sat;
                flags_next.white_to_move = !flags_reg.white_to_move;
            end
            ACT_START:
            begin
                white_next               = load_sat;
                black_next               = load_sat;
                flags_next.white_to_move = 1'b1;
                flags_next.running       = 1'b1;
                flags_next.white_flag    = 1'b0;
                flags_next.black_flag    = 1'b0;
            end
            ACT_STOP:
            begin
                flags_next.running = 1'b0;
            end
            ACT_RESUME:
            begin
                flags_next.running = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (write_cur)
        begin
            if (flags_reg.white_to_move)
                white_next = new_cur;
            else
                black_next = new_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_reg               <= '0;
            black_reg               <= '0;
            flags_reg.white_to_move <= 1'b1;
            flags_reg.running       <= 1'b0;
            flags_reg.white_flag    <= 1'b0;
            flags_reg.black_flag    <= 1'b0;
        end
        else if (accept)
        begin
            white_reg <= white_next;
            black_reg <= black_next;
            flags_reg <= flags_next;
        end
    end

    assign flags_cur = flags_reg;

endmodule

`default_nettype wire

// ===== hdl/icc_show.sv =====
`default_nettype none

module icc_show
    import icc_pkg::*;
#(
    parameter int TIME_BITS = 26
)
(
    input  wire                   clk,
    input  wire stage_en_t        en,
    input  wire  [TIME_BITS-1:0]  ms_next,
    output disp_t                 disp
);

    // ms / 1000 < 2^SEC_W, secs / 60 < 2^MIN_W
    localparam int SEC_W  = TIME_BITS - 9;
    localparam int MIN_W  = SEC_W - 5;
    localparam int P1_W   = TIME_BITS + SEC_W;
    localparam int P2_W   = SEC_W + MIN_W;
    localparam logic [SEC_W-1:0] SEC_RECIP = SEC_W'((64'd1 << TIME_BITS) / MS_PER_SEC);
    localparam logic [MIN_W-1:0] MIN_RECIP = MIN_W'((64'd1 << SEC_W) / SEC_PER_MIN);

    // stage 1
    logic [TIME_BITS-1:0] ms1_reg;
    // stage 2
    logic [P1_W-1:0]      p1_reg;
    logic [TIME_BITS-1:0] ms2_reg;
    // stage 3
    logic [SEC_W-1:0]     q0_reg;
    logic [10:0]          r0_reg;
    // stage 4
    logic [SEC_W-1:0]     secs4_reg;
    logic [9:0]           rem4_reg;
    // stage 5
    logic [P2_W-1:0]      p2_reg;
    logic [SEC_W-1:0]     secs5_reg;
    logic [3:0]           tenths5_reg;
    // stage 6
    logic [MIN_W-1:0]     m0_reg;
    logic [6:0]           r1_reg;
    logic                 over9_reg;
    logic [3:0]           tenths6_reg;
    // stage 7
    disp_t                disp_reg;

    logic [P1_W-1:0]      p1_next;
    logic [SEC_W-1:0]     q0_next;
    logic [TIME_BITS-1:0] r0_full;
    logic [SEC_W-1:0]     secs4_next;
    logic [9:0]           rem4_next;
    logic [P2_W-1:0]      p2_next;
    logic [15:0]          tenth_prod;
    logic [MIN_W-1:0]     m0_next;
    logic [SEC_W-1:0]     r1_full;
    logic [MIN_W-1:0]     mins;
    logic [5:0]           secs_mod;
    logic [31:0]          mins_wide;
    disp_t                disp_next;

    always_comb
    begin
        p1_next = P1_W'(ms1_reg) * P1_W'(SEC_RECIP);

        q0_next = p1_reg[P1_W-1:TIME_BITS];
        r0_full = ms2_reg - TIME_BITS'(q0_next) * TIME_BITS'(MS_PER_SEC);

        if (r0_reg >= 11'(MS_PER_SEC))
        begin
            secs4_next = q0_reg + SEC_W'(1);
            rem4_next  = 10'(r0_reg - 11'(MS_PER_SEC));
        end
        else
        begin
            secs4_next = q0_reg;
            rem4_next  = r0_reg[9:0];
        end

        p2_next    = P2_W'(secs4_reg) * P2_W'(MIN_RECIP);
        tenth_prod = 16'(rem4_reg) * 16'(TENTH_MUL);

        m0_next = p2_reg[P2_W-1:SEC_W];
        r1_full = secs5_reg - SEC_W'(m0_next) * SEC_W'(SEC_PER_MIN);

        if (r1_reg >= 7'(SEC_PER_MIN))
        begin
            mins     = m0_reg + MIN_W'(1);
            secs_mod = 6'(r1_reg - 7'(SEC_PER_MIN));
        end
        else
        begin
            mins     = m0_reg;
            secs_mod = r1_reg[5:0];
        end

        mins_wide         = 32'(mins);
        disp_next.minutes = (mins_wide > 32'(MINUTES_MAX)) ? 11'(MINUTES_MAX)
                                                           : mins_wide[10:0];
        disp_next.seconds = secs_mod;
        disp_next.tenths  = tenths6_reg;
        if (mins_wide > 32'(MIN_MODE_LIMIT))
            disp_next.mode = MODE_MIN;
        else if (over9_reg)
            disp_next.mode = MODE_MIN_SEC;
        else
            disp_next.mode = MODE_SEC_TENTH;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            ms1_reg <= ms_next;
        if (en[2])
        begin
            p1_reg  <= p1_next;
            ms2_reg <= ms1_reg;
        end
        if (en[3])
        begin
            q0_reg <= q0_next;
            r0_reg <= r0_full[10:0];
        end
        if (en[4])
        begin
            secs4_reg <= secs4_next;
            rem4_reg  <= rem4_next;
        end
        if (en[5])
        begin
            p2_reg      <= p2_next;
            secs5_reg   <= secs4_reg;
            tenths5_reg <= tenth_prod[TENTH_SHIFT+3:TENTH_SHIFT];
        end
        if (en[6])
        begin
            m0_reg      <= m0_next;
            r1_reg      <= r1_full[6:0];
            over9_reg   <= (secs5_reg > SEC_W'(SEC_MODE_LIMIT));
            tenths6_reg <= tenths5_reg;
        end
        if (en[7])
            disp_reg <= disp_next;
    end

    assign disp = disp_reg;

endmodule

`default_nettype wire

// ===== hdl/increment_chess_clock.sv =====
// Two-player countdown chess clock with Fischer increment.
//
// Requests enter on the s_* channel: s_tuser carries the action code (tick,
// move, start, stop, resume), s_tdata the elapsed milliseconds for a tick.
// Every accepted request yields exactly one result on m_*: both clocks as
// minutes, seconds and tenths with a display mode, plus turn, running and
// flag bits, as they stand after that request.
// cfg_* writes start time (index 0) and increment (index 1); write only
// while no request is in flight.
//
// m_tvalid rises once a request has passed the input register and both divide
// steps; one request per cycle is sustained while m_tready is high. The clock
// state updates in the accept cycle, then two reciprocal-multiply divide
// steps (by 1000 and by 60), each multiply, back-multiply and correct over
// three registers, form the result.
// Reset zeroes both times, gives white the move, stops the clock and clears
// the flags; config returns to 300000 ms and no increment.
// When m_tready is low the pipeline keeps filling its empty stages and
// s_tready drops only once every stage holds a result.
`default_nettype none

module increment_chess_clock
    import icc_pkg::*;
#(
    parameter int TIME_BITS = 26
)
(
    input  wire          clk,
    input  wire          rst_n,

    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [15:0]  s_tdata,   // [9:0] elapsed_ms
    input  wire  [2:0]   s_tuser,   // [2:0] action

    output logic         m_tvalid,
    input  wire          m_tready,
    // [1:0] white_mode, [12:2] white_minutes, [18:13] white_seconds,
    // [22:19] white_tenths, [24:23] black_mode, [35:25] black_minutes,
    // [41:36] black_seconds, [45:42] black_tenths, [46] white_to_move,
    // [47] running, [48] white_flag, [49] black_flag
    output logic [55:0]  m_tdata,

    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [0:0]   cfg_index,
    input  wire  [START_W-1:0] cfg_data
);

    logic [START_W-1:0]    start_time_reg;
    logic [INC_W-1:0]      increment_reg;

    logic [PIPE_STAGES:1]  v_reg;
    logic [PIPE_STAGES:1]  v_next;
    logic [PIPE_STAGES:1]  ready;
    stage_en_t             en;
    flags_t                flags_pipe_reg [PIPE_STAGES:1];

    logic                  accept;
    logic [TIME_BITS-1:0]  white_next;
    logic [TIME_BITS-1:0]  black_next;
    flags_t                flags_next;
    flags_t                flags_cur;
    disp_t                 white_disp;
    disp_t                 black_disp;
    flags_t                flags_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= START_W'(300000);
            increment_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_TIME: start_time_reg <= cfg_data;
                REG_INCREMENT:  increment_reg  <= cfg_data[INC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        ready[PIPE_STAGES] = !v_reg[PIPE_STAGES] || m_tready;
        for (int k = PIPE_STAGES - 1; k >= 1; k--)
            ready[k] = !v_reg[k] || ready[k+1];

        en[1]     = s_tvalid && ready[1];
        v_next[1] = ready[1] ? s_tvalid : v_reg[1];
        for (int k = 2; k <= PIPE_STAGES; k++)
        begin
            en[k]     = v_reg[k-1] && ready[k];
            v_next[k] = ready[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            flags_pipe_reg[1] <= flags_next;
        for (int k = 2; k <= PIPE_STAGES; k++)
        begin
            if (en[k])
                flags_pipe_reg[k] <= flags_pipe_reg[k-1];
        end
    end

    assign s_tready = ready[1];
    assign accept   = en[1];

    icc_state #(
        .TIME_BITS (TIME_BITS)
    ) u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (s_tuser),
        .elapsed    (s_tdata[ELAPSED_W-1:0]),
        .start_time (start_time_reg),
        .increment  (increment_reg),
        .white_next (white_next),
        .black_next (black_next),
        .flags_next (flags_next),
        .flags_cur  (flags_cur)
    );

    icc_show #(
        .TIME_BITS (TIME_BITS)
    ) u_show_white (
        .clk     (clk),
        .en      (en),
        .ms_next (white_next),
        .disp    (white_disp)
    );

    icc_show #(
        .TIME_BITS (TIME_BITS)
    ) u_show_black (
        .clk     (clk),
        .en      (en),
        .ms_next (black_next),
        .disp    (black_disp)
    );

    assign flags_out = flags_pipe_reg[PIPE_STAGES];
    assign m_tvalid  = v_reg[PIPE_STAGES];
    assign m_tdata   = {6'b0,
                        flags_out.black_flag, flags_out.white_flag,
                        flags_out.running, flags_out.white_to_move,
                        black_disp.tenths, black_disp.seconds,
                        black_disp.minutes, black_disp.mode,
                        white_disp.tenths, white_disp.seconds,
                        white_disp.minutes, white_disp.mode};

`ifndef SYNTH
    // an empty output stage means the whole ready chain is open
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[PIPE_STAGES] |-> s_tready)
        else $error("input stalled with empty output stage");

    a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == ACT_START)) |=>
        (flags_cur.running && flags_cur.white_to_move &&
         !flags_cur.white_flag && !flags_cur.black_flag))
        else $error("start request did not reset clock state");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) |=> $stable(flags_cur))
        else $error("clock state changed without a request");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[1] && !ready[1]) |=> ($stable(flags_pipe_reg[1]) && v_reg[1]))
        else $error("first stage lost its request while stalled");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_increment_chess_clock.sv =====
module tb_increment_chess_clock;
    import icc_pkg::*;

    localparam longint TIME_MAX       = (64'd1 << 26) - 1;
    localparam int     HOLD_CYCLES    = 150;
    localparam int     WATCHDOG_LIMIT = 4000;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;
    logic [2:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [55:0]         m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [0:0]          cfg_index = '0;
    logic [START_W-1:0]  cfg_data  = '0;

    // predicted clock state and settings
    longint start_setting;
    longint increment_setting;
    longint white_ms;
    longint black_ms;
    bit     white_on_move;
    bit     clock_running;
    bit     white_flagged;
    bit     black_flagged;

    logic [55:0] readout_q[$];
    logic [55:0] want;
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    bit          tx_gaps      = 1'b1;
    bit          rx_gaps      = 1'b1;
    bit          hold_pending = 1'b0;

    increment_chess_clock uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // {tenths, seconds, minutes, mode}, mode in the low bits
    function automatic logic [22:0] side_readout(input longint ms);
        longint     secs;
        longint     mins;
        disp_mode_t mode;
        secs = ms / MS_PER_SEC;
        mins = secs / SEC_PER_MIN;
        if (mins > MIN_MODE_LIMIT)
            mode = MODE_MIN;
        else if (secs > SEC_MODE_LIMIT)
            mode = MODE_MIN_SEC;
        else
            mode = MODE_SEC_TENTH;
        if (mins > MINUTES_MAX)
            mins = longint'(MINUTES_MAX);
        return {4'((ms / MS_PER_TENTH) % 10), 6'(secs % SEC_PER_MIN), 11'(mins), mode};
    endfunction

    function automatic longint add_capped(input longint a, input longint b);
        return (a + b > TIME_MAX) ? TIME_MAX : a + b;
    endfunction

    function automatic void advance_clock(input logic [2:0] act, input logic [9:0] el);
        case (act)
            ACT_TICK:
            begin
                if (clock_running)
                begin
                    if (white_on_move)
                    begin
                        if (white_ms > el)
                            white_ms = white_ms - el;
                        else
                        begin
                            white_ms = 0;
                            white_flagged = 1'b1;
                            clock_running = 1'b0;
                        end
                    end
                    else
                    begin
                        if (black_ms > el)
                            black_ms = black_ms - el;
                        else
                        begin
                            black_ms = 0;
                            black_flagged = 1'b1;
                            clock_running = 1'b0;
                        end
                    end
                end
            end
            ACT_MOVE:
            begin
                if (white_on_move)
                    white_ms = add_capped(white_ms, increment_setting);
                else
                    black_ms = add_capped(black_ms, increment_setting);
                white_on_move = !white_on_move;
            end
            ACT_START:
            begin
                white_ms = add_capped(start_setting, 0);
                black_ms = white_ms;
                white_on_move = 1'b1;
                white_flagged = 1'b0;
                black_flagged = 1'b0;
                clock_running = 1'b1;
            end
            ACT_STOP:   clock_running = 1'b0;
            ACT_RESUME: clock_running = 1'b1;
            default:    ;
        endcase
        readout_q.push_back({6'b0, black_flagged, white_flagged, clock_running, white_on_move,
                             side_readout(black_ms), side_readout(white_ms)});
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (readout_q.size() == 0)
            begin
                $error("result with no request outstanding: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = readout_q.pop_front();
                check_field("white_mode",    16'(want[1:0]),   16'(m_tdata[1:0]));
                check_field("white_minutes", 16'(want[12:2]),  16'(m_tdata[12:2]));
                check_field("white_seconds", 16'(want[18:13]), 16'(m_tdata[18:13]));
                check_field("white_tenths",  16'(want[22:19]), 16'(m_tdata[22:19]));
                check_field("black_mode",    16'(want[24:23]), 16'(m_tdata[24:23]));
                check_field("black_minutes", 16'(want[35:25]), 16'(m_tdata[35:25]));
                check_field("black_seconds", 16'(want[41:36]), 16'(m_tdata[41:36]));
                check_field("black_tenths",  16'(want[45:42]), 16'(m_tdata[45:42]));
                check_field("white_to_move", 16'(want[46]),    16'(m_tdata[46]));
                check_field("running",       16'(want[47]),    16'(m_tdata[47]));
                check_field("white_flag",    16'(want[48]),    16'(m_tdata[48]));
                check_field("black_flag",    16'(want[49]),    16'(m_tdata[49]));
                check_field("padding",       16'(want[55:50]), 16'(m_tdata[55:50]));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("[increment_chess_clock] ERROR");
                $finish;
            end
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !rx_gaps || ($urandom_range(99) >= 29);
        end
    end

    task automatic send_request(input logic [2:0] act, input logic [9:0] el);
        if (tx_gaps)
            while ($urandom_range(99) < 29)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, el};
        do @(posedge clk); while (!s_tready);
        advance_clock(act, el);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (readout_q.size() != 0) @(posedge clk);
        repeat (PIPE_STAGES + 2) @(posedge clk);
    endtask

    task automatic write_settings(input logic [25:0] start_ms, input logic [25:0] inc_ms);
        cfg_valid <= 1'b1;
        cfg_index <= REG_START_TIME;
        cfg_data  <= start_ms;
        do @(posedge clk); while (!cfg_ready);
        start_setting = longint'(start_ms);
        cfg_index <= REG_INCREMENT;
        cfg_data  <= inc_ms;
        do @(posedge clk); while (!cfg_ready);
        increment_setting = longint'(inc_ms & 26'h3FFFFF);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic play_game(input int count);
        int         roll;
        logic [9:0] el;
        el = 10'($urandom_range(1023));
        send_request(ACT_START, el);
        for (int i = 1; i < count; i++)
        begin
            roll = $urandom_range(99);
            el   = 10'($urandom_range(1023));
            if ((white_flagged || black_flagged) && roll < 30)
                send_request(ACT_START, el);
            else if (roll < 60)
                send_request(ACT_TICK, el);
            else if (roll < 80)
                send_request(ACT_MOVE, el);
            else if (roll < 86)
                send_request(ACT_STOP, el);
            else if (roll < 92)
                send_request(ACT_RESUME, el);
            else if (roll < 96)
                send_request(ACT_START, el);
            else
                send_request(3'($urandom_range(5, 7)), el);
        end
    endtask

    task automatic test_reset_defaults();
        send_request(ACT_TICK, 10'd0);
        send_request(ACT_START, 10'd1023);
    endtask

    task automatic test_operations();
        send_request(ACT_TICK, 10'd1023);
        send_request(ACT_TICK, 10'd0);
        send_request(ACT_MOVE, 10'd0);
        send_request(ACT_TICK, 10'd1023);
        send_request(ACT_STOP, 10'd0);
        send_request(ACT_TICK, 10'd500);    // stopped: no change
        send_request(ACT_MOVE, 10'd0);      // still passes the turn
        send_request(ACT_RESUME, 10'd0);
        send_request(3'd5, 10'h2AA);        // unused codes
        send_request(3'd6, 10'h155);
        send_request(3'd7, 10'h3FF);
    endtask

    task automatic test_flag_fall();
        settle();
        write_settings(26'd1500, 26'd100);
        send_request(ACT_START, 10'd0);
        send_request(ACT_TICK, 10'd1023);
        send_request(ACT_TICK, 10'd1023);   // white falls
        send_request(ACT_RESUME, 10'd0);
        send_request(ACT_TICK, 10'd0);      // zero time flags again
        send_request(ACT_MOVE, 10'd0);
        send_request(ACT_START, 10'd0);
    endtask

    task automatic test_zero_start();
        settle();
        write_settings(26'd0, 26'd0);
        send_request(ACT_START, 10'd0);
        send_request(ACT_TICK, 10'd0);
    endtask

    task automatic test_saturation();
        settle();
        write_settings(26'h3FFFFFF, 26'd3600000);
        send_request(ACT_START, 10'd0);
        send_request(ACT_MOVE, 10'd0);
        send_request(ACT_MOVE, 10'd0);
        send_request(ACT_TICK, 10'd1023);
    endtask

    task automatic test_random_games();
        logic [25:0] start_ms;
        logic [25:0] inc_ms;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin start_ms = 26'd5000;    inc_ms = 26'd2000; end
                1: begin start_ms = 26'd1;       inc_ms = 26'd0; end
                2:
                begin
                    start_ms = 26'($urandom_range(60000, 1000));
                    inc_ms   = 26'($urandom_range(5000));
                end
                3: begin start_ms = 26'h3FFFFFF; inc_ms = 26'd3600000; end
                4:
                begin
                    start_ms = 26'($urandom_range(6100000, 5900000));
                    inc_ms   = 26'd0;
                end
                5: begin start_ms = 26'd0;       inc_ms = 26'd3600000; end
                6:
                begin
                    start_ms = 26'($urandom);
                    inc_ms   = 26'($urandom_range(3600000));
                end
                default: begin start_ms = 26'd300000; inc_ms = 26'd0; end
            endcase
            settle();
            write_settings(start_ms, inc_ms);
            for (int g = 0; g < 5; g++)
                play_game(30);
        end
    endtask

    task automatic test_full_pipeline();
        settle();
        write_settings(26'd20000, 26'd1000);
        tx_gaps = 1'b0;
        hold_pending = 1'b1;
        play_game(60);
        tx_gaps = 1'b1;
    endtask

    task automatic test_steady_stream();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        play_game(100);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    initial
    begin : main_flow
        start_setting     = 300000;
        increment_setting = 0;
        white_ms          = 0;
        black_ms          = 0;
        white_on_move     = 1'b1;
        clock_running     = 1'b0;
        white_flagged     = 1'b0;
        black_flagged     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_operations();
        test_flag_fall();
        test_zero_start();
        test_saturation();
        test_random_games();
        test_full_pipeline();
        test_steady_stream();
        settle();
        if (mismatches == 0)
            $display("[increment_chess_clock] OK");
        else
            $display("[increment_chess_clock] ERROR");
        $finish;
    end

endmodule

// ===== increment_chess_clock.f =====
hdl/icc_pkg.sv
hdl/icc_state.sv
hdl/icc_show.sv
hdl/increment_chess_clock.sv
dv/tb_increment_chess_clock.sv
